/* design/tswa_pkg.sv */
// ----------------------------------------------------------------------------
// tswa_pkg
// Shared constants and controller/datapath interface types for the touch
// sample window averager.
// ----------------------------------------------------------------------------
`default_nettype none

package tswa_pkg;

    // Width of one raw touch coordinate.
    localparam int SAMPLE_W = 12;

    // Request codes carried on the action field.
    localparam logic ACT_SAMPLE = 1'b0;   // coordinate sample while touched
    localparam logic ACT_END    = 1'b1;   // touch ended

    // Controller -> datapath commands.
    typedef struct packed {
        logic smp_start;   // sample request accepted: latch it, read old slot
        logic end_start;   // touch-end request accepted: load divider, clear touch
        logic update;      // fold sample into sums, write ring, bump pointer
        logic div_step;    // one restoring-division step on x and y
        logic out_load;    // load result register
    } t_cmd;

    // Datapath -> controller status.
    typedef struct packed {
        logic count_zero;  // no samples held for the current touch
    } t_stat;

endpackage

`default_nettype wire

/* design/touch_sample_window_averager.sv */
// ----------------------------------------------------------------------------
// touch_sample_window_averager
// Keeps the last WINDOW touch coordinate samples and, on touch end, returns
// the truncated mean of the held x and y samples for the named panel.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready): one request per handshake.
//     i_action = 0 is a coordinate sample, i_action = 1 ends the touch.
//   Output channel (o_out_valid / i_out_ready): one result per touch end,
//     none for samples. o_no_samples flags a touch that had no samples;
//     the means are then 0.
//   Sequencing: a sample reads the old slot from the ring, then does the
//     sum update and ring write; the input is closed meanwhile. A touch end
//     runs the bit-serial divider, one quotient bit per cycle, over a
//     SUM_W-bit quotient, SUM_W = 12 + clog2(WINDOW+1) (22 at WINDOW = 512).
//     The input stays closed until the result register is loaded.
//     A touch end with no samples skips the divider.
//   Stall: the result sits in an output register; a new request is taken
//   while it waits. A second touch end finishing before the first result
//   is taken holds in the controller until the register frees.
//   Reset: clears count, pointer, sums and the output valid. Ring contents
//   are not cleared; stale entries are never read.
// ----------------------------------------------------------------------------
`default_nettype none

module touch_sample_window_averager import tswa_pkg::*; #(
    parameter int WINDOW = 512
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire logic                i_action,
    input  wire logic                i_panel,
    input  wire logic [SAMPLE_W-1:0] i_sample_x,
    input  wire logic [SAMPLE_W-1:0] i_sample_y,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output logic                     o_which_panel,
    output logic      [SAMPLE_W-1:0] o_mean_x,
    output logic      [SAMPLE_W-1:0] o_mean_y,
    output logic                     o_no_samples
);

    // count holds 0..WINDOW; sums hold WINDOW full-scale samples
    localparam int CNT_W = $clog2(WINDOW + 1);
    localparam int SUM_W = SAMPLE_W + CNT_W;

    t_cmd  cmd;
    t_stat stat;

    tswa_ctrl #(
        .DIV_STEPS (SUM_W)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_action    (i_action),
        .i_out_ready (i_out_ready),
        .i_stat      (stat),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd)
    );

    tswa_dp #(
        .WINDOW (WINDOW),
        .CNT_W  (CNT_W),
        .SUM_W  (SUM_W)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_panel       (i_panel),
        .i_sample_x    (i_sample_x),
        .i_sample_y    (i_sample_y),
        .o_which_panel (o_which_panel),
        .o_mean_x      (o_mean_x),
        .o_mean_y      (o_mean_y),
        .o_no_samples  (o_no_samples)
    );

`ifndef SYNTHESIS
    // a sample request always moves to its update with the input closed
    a_smp_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (i_action == ACT_SAMPLE) |=> !o_in_ready)
        else $error("sample accepted without update cycle");

    // a touch-end request closes the input after it is taken
    a_end_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (i_action == ACT_END) |=> !o_in_ready)
        else $error("touch end accepted without busy period");

    // an empty touch reports zero means
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_no_samples |-> o_mean_x == '0 && o_mean_y == '0)
        else $error("empty touch with nonzero mean");

    // a result appears only after a touch-end request was in flight
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> !$past(o_in_ready))
        else $error("result without touch end");
`endif

endmodule

`default_nettype wire

/* design/tswa_ram.sv */
// ----------------------------------------------------------------------------
// tswa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tswa_ram #(
    parameter int WIDTH  = 24,
    parameter int DEPTH  = 512,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic              i_re,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

/* design/tswa_dp.sv */
// ----------------------------------------------------------------------------
// tswa_dp
// Datapath: sample ring, running sums, count, pointer, two restoring
// dividers sharing one step sequence, and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module tswa_dp import tswa_pkg::*; #(
    parameter int WINDOW = 512,
    parameter int CNT_W  = $clog2(WINDOW + 1),
    parameter int SUM_W  = SAMPLE_W + CNT_W
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire t_cmd                i_cmd,
    output t_stat                    o_stat,
    input  wire logic                i_panel,
    input  wire logic [SAMPLE_W-1:0] i_sample_x,
    input  wire logic [SAMPLE_W-1:0] i_sample_y,
    output logic                     o_which_panel,
    output logic      [SAMPLE_W-1:0] o_mean_x,
    output logic      [SAMPLE_W-1:0] o_mean_y,
    output logic                     o_no_samples
);

    localparam int PTR_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;

    // touch state
    logic [PTR_W-1:0]    r_ptr,   n_ptr;
    logic [CNT_W-1:0]    r_cnt,   n_cnt;
    logic [SUM_W-1:0]    r_sum_x, n_sum_x;
    logic [SUM_W-1:0]    r_sum_y, n_sum_y;

    // latched request
    logic [SAMPLE_W-1:0] r_sx, r_sy;
    logic                r_panel, r_no_smp;

    // divider
    logic [SUM_W-1:0]    r_qx, r_qy, n_qx, n_qy;
    logic [CNT_W-1:0]    r_remx, r_remy, n_remx, n_remy;
    logic [CNT_W-1:0]    r_div;
    logic [CNT_W:0]      shx, shy;

    logic [2*SAMPLE_W-1:0] ram_rdata;
    logic [SAMPLE_W-1:0]   old_x, old_y;
    logic                  full;

    tswa_ram #(
        .WIDTH (2 * SAMPLE_W),
        .DEPTH (WINDOW)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (i_cmd.update),
        .i_waddr (r_ptr),
        .i_wdata ({r_sx, r_sy}),
        .i_re    (i_cmd.smp_start),
        .i_raddr (r_ptr),
        .o_rdata (ram_rdata)
    );

    assign old_x = ram_rdata[2*SAMPLE_W-1:SAMPLE_W];
    assign old_y = ram_rdata[SAMPLE_W-1:0];
    assign full  = (r_cnt == CNT_W'(WINDOW));

    assign o_stat.count_zero = (r_cnt == '0);

    // sums, count, pointer
    always_comb begin
        n_ptr   = r_ptr;
        n_cnt   = r_cnt;
        n_sum_x = r_sum_x;
        n_sum_y = r_sum_y;
        if (i_cmd.end_start) begin
            n_ptr   = '0;
            n_cnt   = '0;
            n_sum_x = '0;
            n_sum_y = '0;
        end else if (i_cmd.update) begin
            // oldest sample drops out once the window is full
            n_sum_x = r_sum_x - (full ? SUM_W'(old_x) : '0) + SUM_W'(r_sx);
            n_sum_y = r_sum_y - (full ? SUM_W'(old_y) : '0) + SUM_W'(r_sy);
            if (!full) begin
                n_cnt = r_cnt + CNT_W'(1);
            end
            n_ptr = (r_ptr == PTR_W'(WINDOW - 1)) ? '0 : r_ptr + PTR_W'(1);
        end
    end

    // restoring division, one quotient bit per step
    always_comb begin
        shx    = {r_remx, r_qx[SUM_W-1]};
        shy    = {r_remy, r_qy[SUM_W-1]};
        n_remx = shx[CNT_W-1:0];
        n_remy = shy[CNT_W-1:0];
        n_qx   = {r_qx[SUM_W-2:0], 1'b0};
        n_qy   = {r_qy[SUM_W-2:0], 1'b0};
        if (shx >= {1'b0, r_div}) begin
            n_remx = CNT_W'(shx - {1'b0, r_div});
            n_qx[0] = 1'b1;
        end
        if (shy >= {1'b0, r_div}) begin
            n_remy = CNT_W'(shy - {1'b0, r_div});
            n_qy[0] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr   <= '0;
            r_cnt   <= '0;
            r_sum_x <= '0;
            r_sum_y <= '0;
        end else begin
            r_ptr   <= n_ptr;
            r_cnt   <= n_cnt;
            r_sum_x <= n_sum_x;
            r_sum_y <= n_sum_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.smp_start) begin
            r_sx <= i_sample_x;
            r_sy <= i_sample_y;
        end
        if (i_cmd.end_start) begin
            r_panel  <= i_panel;
            r_no_smp <= (r_cnt == '0);
            r_qx     <= r_sum_x;
            r_qy     <= r_sum_y;
            r_remx   <= '0;
            r_remy   <= '0;
            r_div    <= r_cnt;
        end else if (i_cmd.div_step) begin
            r_qx   <= n_qx;
            r_qy   <= n_qy;
            r_remx <= n_remx;
            r_remy <= n_remy;
        end
        if (i_cmd.out_load) begin
            o_which_panel <= r_panel;
            o_no_samples  <= r_no_smp;
            o_mean_x      <= r_no_smp ? '0 : r_qx[SAMPLE_W-1:0];
            o_mean_y      <= r_no_smp ? '0 : r_qy[SAMPLE_W-1:0];
        end
    end

endmodule

`default_nettype wire

/* design/tswa_ctrl.sv */
// ----------------------------------------------------------------------------
// tswa_ctrl
// Controller: request sequencing, division step counter, result valid.
// ----------------------------------------------------------------------------
`default_nettype none

module tswa_ctrl import tswa_pkg::*; #(
    parameter int DIV_STEPS = 22
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    input  wire logic i_action,
    input  wire logic i_out_ready,
    input  wire t_stat i_stat,
    output logic      o_in_ready,
    output logic      o_out_valid,
    output t_cmd      o_cmd
);

    localparam int STEP_W = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_UPD  = 4'b0010,
        S_DIV  = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    t_state            r_state, n_state;
    logic [STEP_W-1:0] r_step,  n_step;
    logic              r_out_valid, n_out_valid;
    logic              accept;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign accept      = i_in_valid && o_in_ready;

    always_comb begin
        o_cmd.smp_start = accept && (i_action == ACT_SAMPLE);
        o_cmd.end_start = accept && (i_action == ACT_END);
        o_cmd.update    = (r_state == S_UPD);
        o_cmd.div_step  = (r_state == S_DIV);
        o_cmd.out_load  = (r_state == S_DONE) && (!r_out_valid || i_out_ready);
    end

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        unique case (r_state)
            S_IDLE: begin
                n_step = '0;
                if (accept) begin
                    if (i_action == ACT_SAMPLE) begin
                        n_state = S_UPD;
                    end else if (i_stat.count_zero) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_DIV;
                    end
                end
            end
            S_UPD: begin
                n_state = S_IDLE;
            end
            S_DIV: begin
                n_step = r_step + STEP_W'(1);
                if (r_step == STEP_W'(DIV_STEPS - 1)) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (o_cmd.out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

`default_nettype wire
